/* rtl/assert_macros.svh */
// Assertion macros for the sampler RTL.
// Included by the top level; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
  else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
  else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst, a, c)
`define CHK_NEXT(label, clk, rst, a, c)
`endif
`endif

/* rtl/chs_pkg.sv */
// Package for the cosine hemisphere sampler: fixed-point constants, Q30 multiply.
// No dependencies.
`default_nettype none
package chs_pkg;
  localparam int FRAC = 30;
  localparam logic [31:0] ONE_Q = 32'h4000_0000;
  localparam logic [31:0] PI4_Q = 32'd843314857;
  localparam logic [31:0] INVPI_Q = 32'd341782638;

  // (p*q + 2^29) >> 30, operands below 2^32
  function automatic logic [31:0] mulq(input logic [31:0] p, input logic [31:0] q);
    logic [63:0] prod;
    prod = 64'(p) * 64'(q) + 64'h2000_0000;
    return prod[61:30];
  endfunction

  // floor(x / d) for the Horner divisors, x < 2^31: shift out the power of two,
  // then multiply by the rounded-up reciprocal of the odd part
  function automatic logic [31:0] div_horner(input logic [31:0] x, input logic [31:0] d);
    logic [1:0]  a;
    logic [5:0]  s;
    logic [31:0] m;
    logic [63:0] prod;
    case (d)
      32'd72: begin a = 2'd3; s = 6'd34; m = 32'd1908874354; end
      32'd42: begin a = 2'd1; s = 6'd35; m = 32'd1636178018; end
      32'd20: begin a = 2'd2; s = 6'd33; m = 32'd1717986919; end
      32'd6:  begin a = 2'd1; s = 6'd32; m = 32'd1431655766; end
      32'd56: begin a = 2'd3; s = 6'd33; m = 32'd1227133514; end
      32'd30: begin a = 2'd1; s = 6'd34; m = 32'd1145324613; end
      32'd12: begin a = 2'd2; s = 6'd32; m = 32'd1431655766; end
      // divide by two
      default: begin a = 2'd1; s = 6'd30; m = 32'h4000_0000; end
    endcase
    prod = 64'(x >> a) * 64'(m);
    return 32'(prod >> s);
  endfunction
endpackage
`default_nettype wire

/* rtl/chs_div.sv */
// Pipelined restoring divider: q = floor(n * 2^30 / d), n <= d, one quotient bit a stage.
// Uses chs_pkg.
`default_nettype none
module chs_div
  import chs_pkg::*;
#(
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic [31:0]   num,
  input  wire logic [31:0]   den,
  input  wire logic [TW-1:0] tag_in,
  output logic      [31:0]   quo,
  output logic      [TW-1:0] tag_out
);
  // stage k produces quotient bit 30-k
  logic [32:0] rem [0:31];
  logic [31:0] dd  [0:31];
  logic [31:0] qq  [0:31];
  logic [TW-1:0] tg [0:31];

  always_ff @(posedge clk) begin
    rem[0] <= {1'b0, num};
    dd[0] <= den;
    qq[0] <= '0;
    tg[0] <= tag_in;
  end

  for (genvar k = 0; k < 31; k++) begin : g_st
    logic [33:0] sh;
    logic        ge;
    assign sh = {rem[k], 1'b0};
    assign ge = (k == 0) ? ({1'b0, rem[k]} >= {2'b0, dd[k]}) : (sh >= {2'b0, dd[k]});
    always_ff @(posedge clk) begin
      if (k == 0) begin
        rem[k+1] <= ge ? rem[k] - {1'b0, dd[k]} : rem[k];
      end else begin
        rem[k+1] <= ge ? 33'(sh - {2'b0, dd[k]}) : sh[32:0];
      end
      qq[k+1] <= {qq[k][30:0], ge};
      dd[k+1] <= dd[k];
      tg[k+1] <= tg[k];
    end
  end

  assign quo = qq[31];
  assign tag_out = tg[31];
endmodule
`default_nettype wire

/* rtl/chs_sqrt.sv */
// Pipelined integer square root of a 62-bit value, two radicand bits a stage.
// No package use beyond widths.
`default_nettype none
module chs_sqrt #(
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic [61:0]   rad,
  input  wire logic [TW-1:0] tag_in,
  output logic      [30:0]   root,
  output logic      [TW-1:0] tag_out
);
  logic [61:0] v  [0:31];
  logic [62:0] rs [0:31];
  logic [TW-1:0] tg [0:31];

  always_ff @(posedge clk) begin
    v[0] <= rad;
    rs[0] <= '0;
    tg[0] <= tag_in;
  end

  // classic digit-by-digit: bit = 4^(30-k)
  for (genvar k = 0; k < 31; k++) begin : g_st
    localparam logic [62:0] BIT = 63'(1) << (2 * (30 - k));
    logic [62:0] trial;
    assign trial = rs[k] + BIT;
    always_ff @(posedge clk) begin
      if ({1'b0, v[k]} >= trial) begin
        v[k+1] <= 62'({1'b0, v[k]} - trial);
        rs[k+1] <= (rs[k] >> 1) + BIT;
      end else begin
        v[k+1] <= v[k];
        rs[k+1] <= rs[k] >> 1;
      end
      tg[k+1] <= tg[k];
    end
  end

  assign root = rs[31][30:0];
  assign tag_out = tg[31];
endmodule
`default_nettype wire

/* rtl/cosine_hemisphere_sampler_unit.sv */
// Cosine-weighted hemisphere sampler, concentric disk mapping, Q30 datapath.
// Throughput one item per cycle (busy stays low). Depth is set by the 31-stage divider,
// the 31-stage square root and the polynomial multiply chain. Sync reset clears the
// valid pipeline only.
// Results cannot be stalled; done marks each result for one cycle.
`default_nettype none
`include "assert_macros.svh"
module cosine_hemisphere_sampler_unit
  import chs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int OUT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [SAMPLE_BITS-1:0] u_sample,
  input  wire logic [SAMPLE_BITS-1:0] v_sample,
  output logic                       done,
  output logic signed [OUT_BITS-1:0] dir_x,
  output logic signed [OUT_BITS-1:0] dir_y,
  output logic        [OUT_BITS-2:0] dir_z,
  output logic        [OUT_BITS-3:0] density
);
  localparam int FB = SAMPLE_BITS - 1;
  localparam int DLAT = 32;
  localparam int SLAT = 32;
  localparam int PRE = 2;
  localparam int MID = 14;
  localparam int LAT = PRE + DLAT + MID + SLAT + 2;

  assign busy = 1'b0;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end

  // sample map to Q30 magnitude with sign
  function automatic logic [32:0] map_s(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] m;
    logic n;
    logic [31:0] q;
    n = !s[FB];
    m = n ? SAMPLE_BITS'((SAMPLE_BITS+1)'(1) << FB) - s : s - (SAMPLE_BITS'(1) << FB);
    if (FB <= FRAC) q = 32'(64'(m) << (FRAC - FB));
    else if (n) q = 32'((64'(m) + (64'(1) << (FB - FRAC)) - 64'd1) >> (FB - FRAC));
    else q = 32'(64'(m) >> (FB - FRAC));
    return {n && (q != 0), q};
  endfunction

  // stage 1: map
  logic [31:0] am, bm;
  logic an, bn;
  always_ff @(posedge clk) begin
    {an, am} <= map_s(u_sample);
    {bn, bm} <= map_s(v_sample);
  end

  // stage 2: select larger
  logic [31:0] rm1, sm1;
  logic rn1, on1, first1, zero1;
  always_ff @(posedge clk) begin
    first1 <= am > bm;
    rm1 <= (am > bm) ? am : bm;
    sm1 <= (am > bm) ? bm : am;
    rn1 <= (am > bm) ? an : bn;
    on1 <= (am > bm) ? bn : an;
    zero1 <= (am == 0) && (bm == 0);
  end

  // tag: rm, first, rn, on, zero
  localparam int TW = 36;
  logic [TW-1:0] dtag;
  logic [31:0] t0;
  chs_div #(.TW(TW)) u_div (
    .clk(clk), .num(sm1), .den(zero1 ? 32'd1 : rm1),
    .tag_in({rm1, first1, rn1, on1, zero1}), .quo(t0), .tag_out(dtag)
  );

  // middle stages: angle, polynomials, x/y, r2
  logic [31:0] rm_p [0:10];
  logic first_p [0:10], rn_p [0:10], tn_p [0:10], zero_p [0:10];
  logic [31:0] p_r, w_r;
  logic [31:0] hs [0:4];
  logic [31:0] hc [0:4];
  logic [31:0] ms_r [0:3];
  logic [31:0] mc_r [0:3];
  logic [31:0] sv_r, cv_r, xm_r, ym_r, xx_r, yy_r, r2_r;
  logic xn_r, yn_r;

  always_ff @(posedge clk) begin
    rm_p[0] <= dtag[35:4];
    first_p[0] <= dtag[3];
    rn_p[0] <= dtag[2];
    tn_p[0] <= (dtag[1] != dtag[2]) && (t0 != 0);
    zero_p[0] <= dtag[0];
    p_r <= mulq(t0, PI4_Q);
  end
  for (genvar i = 0; i < 10; i++) begin : g_tag
    always_ff @(posedge clk) begin
      rm_p[i+1] <= rm_p[i];
      first_p[i+1] <= first_p[i];
      rn_p[i+1] <= rn_p[i];
      tn_p[i+1] <= tn_p[i];
      zero_p[i+1] <= zero_p[i];
    end
  end

  // p is valid at index 1; w at 2; each Horner step takes mul stage + div stage
  logic [31:0] p_d [0:8];
  always_ff @(posedge clk) begin
    w_r <= mulq(p_r, p_r);
    p_d[0] <= p_r;
  end
  for (genvar i = 0; i < 8; i++) begin : g_pd
    always_ff @(posedge clk) p_d[i+1] <= p_d[i];
  end
  logic [31:0] w_d [0:5];
  always_ff @(posedge clk) w_d[0] <= w_r;
  for (genvar i = 0; i < 5; i++) begin : g_wd
    always_ff @(posedge clk) w_d[i+1] <= w_d[i];
  end

  assign hs[0] = ONE_Q;
  assign hc[0] = ONE_Q;
  for (genvar k = 0; k < 4; k++) begin : g_h
    localparam logic [31:0] DS = (k == 0) ? 32'd72 : (k == 1) ? 32'd42 :
                                 (k == 2) ? 32'd20 : 32'd6;
    localparam logic [31:0] DC = (k == 0) ? 32'd56 : (k == 1) ? 32'd30 :
                                 (k == 2) ? 32'd12 : 32'd2;
    logic [31:0] ws;
    logic [31:0] hs_q, hc_q;
    if (k == 0) begin : g_w0
      assign ws = w_r;
    end else begin : g_wn
      assign ws = w_d[2*k-1];
    end
    always_ff @(posedge clk) begin
      ms_r[k] <= mulq(ws, hs[k]);
      mc_r[k] <= mulq(ws, hc[k]);
    end
    always_ff @(posedge clk) begin
      hs_q <= ONE_Q - div_horner(ms_r[k], DS);
      hc_q <= ONE_Q - div_horner(mc_r[k], DC);
    end
    assign hs[k+1] = hs_q;
    assign hc[k+1] = hc_q;
  end
  // hs[4] valid at index 10 (p_r at 1): sin mul next
  logic [31:0] hc_d;
  always_ff @(posedge clk) begin
    sv_r <= mulq(p_d[8], hs[4]);
    hc_d <= hc[4];
  end
  assign cv_r = hc_d;
  // index 11: x/y
  always_ff @(posedge clk) begin
    if (zero_p[10]) begin
      xm_r <= '0;
      ym_r <= '0;
    end else begin
      xm_r <= mulq(rm_p[10], first_p[10] ? cv_r : sv_r);
      ym_r <= mulq(rm_p[10], first_p[10] ? sv_r : cv_r);
    end
    xn_r <= first_p[10] ? rn_p[10] : (rn_p[10] != tn_p[10]);
    yn_r <= first_p[10] ? (rn_p[10] != tn_p[10]) : rn_p[10];
  end
  always_ff @(posedge clk) begin
    xx_r <= mulq(xm_r, xm_r);
    yy_r <= mulq(ym_r, ym_r);
  end
  always_ff @(posedge clk) r2_r <= xx_r + yy_r;

  logic [31:0] xm_d [0:1];
  logic [31:0] ym_d [0:1];
  logic xn_d [0:1], yn_d [0:1];
  always_ff @(posedge clk) begin
    xm_d[0] <= xm_r; ym_d[0] <= ym_r; xn_d[0] <= xn_r; yn_d[0] <= yn_r;
    xm_d[1] <= xm_d[0]; ym_d[1] <= ym_d[0]; xn_d[1] <= xn_d[0]; yn_d[1] <= yn_d[0];
  end

  // square root of (1 - r2) << 30; 1 - r2 can reach 2^30 itself
  logic over;
  logic [61:0] rad;
  assign over = r2_r > ONE_Q;
  assign rad = over ? '0 : {1'b0, 31'(ONE_Q - r2_r), 30'd0};
  logic [66:0] sq_tag;
  logic [30:0] zroot;
  chs_sqrt #(.TW(67)) u_sqrt (
    .clk(clk), .rad(rad),
    .tag_in({xm_d[1][31:0], ym_d[1][31:0], xn_d[1], yn_d[1], over}),
    .root(zroot), .tag_out(sq_tag)
  );

  // rescale and saturate
  function automatic logic [OUT_BITS-1:0] enc_s(input logic [31:0] m, input logic n);
    logic [63:0] v;
    logic [63:0] top;
    top = 64'(1) << (OUT_BITS - 1);
    if (OUT_BITS - 1 >= FRAC) v = 64'(m) << (OUT_BITS - 1 - FRAC);
    else v = (64'(m) + (64'(1) << (FRAC - OUT_BITS))) >> (FRAC - OUT_BITS + 1);
    if (n && v != 0) begin
      if (v > top) v = top;
      return OUT_BITS'(64'd0 - v);
    end
    if (v > top - 64'd1) v = top - 64'd1;
    return OUT_BITS'(v);
  endfunction
  function automatic logic [63:0] enc_u(input logic [31:0] m, input int w);
    logic [63:0] v, lim;
    lim = (64'(1) << w) - 64'd1;
    if (OUT_BITS - 1 >= FRAC) v = 64'(m) << (OUT_BITS - 1 - FRAC);
    else v = (64'(m) + (64'(1) << (FRAC - OUT_BITS))) >> (FRAC - OUT_BITS + 1);
    return (v > lim) ? lim : v;
  endfunction

  logic [31:0] z_r, pdf_r;
  logic [66:0] tg_r;
  always_ff @(posedge clk) begin
    z_r <= sq_tag[0] ? 32'd0 : {1'b0, zroot};
    tg_r <= sq_tag;
  end
  always_ff @(posedge clk) begin
    pdf_r <= mulq(z_r, INVPI_Q);
    dir_x <= enc_s(tg_r[66:35], tg_r[2]);
    dir_y <= enc_s(tg_r[34:3], tg_r[1]);
    dir_z <= (OUT_BITS-1)'(enc_u(z_r, OUT_BITS - 1));
  end
  assign density = (OUT_BITS-2)'(enc_u(pdf_r, OUT_BITS - 2));
  assign done = vld[LAT-1];

  `CHK_IMPL(a_never_busy, clk, rst, 1'b1, !busy)
  `CHK_NEXT(a_done_follows, clk, rst, vld[LAT-2], done)
  `CHK_IMPL(a_density_range, clk, rst, done, density <= (OUT_BITS-2)'(enc_u(INVPI_Q, OUT_BITS-2)))
endmodule
`default_nettype wire
